>>> rtl/shuffle_picker_recent_inhibit_top_defines.svh
// Assertion macros used by the shuffle picker top level.
`ifndef SHUFFLE_PICKER_RECENT_INHIBIT_TOP_DEFINES_SVH
`define SHUFFLE_PICKER_RECENT_INHIBIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPRI_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shuffle picker check failed");
`define SPRI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shuffle picker check failed");
`else
`define SPRI_ASSERT_SAME(name, clk, rst, ante, cons)
`define SPRI_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/spri_pkg.sv
// Package with the opcodes, ring entry type, constants and generator step of the picker.
package spri_pkg;

  typedef enum logic [1:0] {
    OP_SEED = 2'd0,
    OP_ADD  = 2'd1,
    OP_PICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] expiry;
  } ring_entry_t;

  localparam int unsigned ENTRY_W = $bits(ring_entry_t);
  localparam logic [63:0] LFSR_FILL = 64'h1234_5678_dead_beef;
  localparam logic [15:0] MIN_SONGS = 16'd3;
  localparam logic [31:0] DIV5_MUL = 32'd52429;
  localparam int unsigned DIV5_SHIFT = 18;
  localparam int unsigned ATTEMPT_W = 16;

  function automatic logic [63:0] prng_step(input logic [63:0] s_in,
                                            input logic [31:0] mix);
    logic [63:0] s;
    logic fb;
    s = (s_in == 64'd0) ? LFSR_FILL : s_in;
    fb = s[0] ^ s[1] ^ s[3] ^ s[4];
    return {fb, s[63:1]} ^ {32'd0, mix};
  endfunction

endpackage

>>> rtl/spri_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spri_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/spri_mod.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo a 16-bit divisor.
module spri_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic        run;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [15:0] div;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted = {remainder, dvd[31]};
  assign diff = shifted - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        dvd <= dividend;
        div <= divisor;
        remainder <= '0;
      end else if (run) begin
        remainder <= diff[16] ? shifted[15:0] : diff[15:0];
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/shuffle_picker_recent_inhibit_top.sv
// Top level of the shuffle picker: sequencer, generator, recent ring and result registers.
//
//   channel   handshake              payload
//   input     start & !busy          opcode entropy song_id song_length_seconds
//                                    current_time prev_track
//   config    cfg_we                 cfg_wdata (song count)
//   result    done (one cycle)       track attempts gave_up error
//
// After reset the ring is cleared, every slot in turn, with busy high.
// Add writes its entry to the next ring slot; an error or unused opcode answers from idle; seed makes one draw.
// Each pick draw advances the generator and reduces it in the serial remainder unit, then,
// unless it repeats the previous track, scans the ring through its one read port.
// A pick makes up to MAX_ATTEMPTS draws before it gives up.
// The receiver cannot stall; each result is shown for one cycle on done.
`include "shuffle_picker_recent_inhibit_top_defines.svh"
module shuffle_picker_recent_inhibit_top #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned MAX_ATTEMPTS = 500
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] entropy,
  input  logic [15:0] song_id,
  input  logic [15:0] song_length_seconds,
  input  logic [15:0] current_time,
  input  logic [15:0] prev_track,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        done,
  output logic [15:0] track,
  output logic [8:0]  attempts,
  output logic        gave_up,
  output logic        error
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned AWN = spri_pkg::ATTEMPT_W;
  localparam logic [CW-1:0] SCAN_END = CW'(RING_DEPTH);
  localparam logic [AW-1:0] SLOT_LAST = AW'(RING_DEPTH - 1);
  localparam logic [AWN-1:0] TRY_LIMIT = AWN'(MAX_ATTEMPTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_DRAW,
    S_MOD,
    S_SCAN
  } state_t;

  state_t state;

  logic [15:0]  song_count;
  logic [63:0]  lfsr;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] scan_cnt;
  logic          pend;
  logic [AWN-1:0] tries;

  spri_pkg::opcode_t op_q;
  logic [31:0] ent_q;
  logic [15:0] id_q;
  logic [15:0] now_q;
  logic [15:0] prev_q;
  logic [15:0] quot_q;
  logic [15:0] trk_q;

  logic        accept;
  logic        count_ok;
  logic [63:0] gen_in;
  logic [31:0] gen_mix;
  logic [63:0] gen_out;
  logic        mod_start;
  logic        mod_done;
  logic [15:0] mod_rem;
  logic [31:0] div_prod;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  spri_pkg::ring_entry_t ram_wdata;
  spri_pkg::ring_entry_t ram_rdata;
  logic [15:0]           exp_diff;
  logic                  hit;
  logic                  tries_full;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign count_ok = (song_count >= spri_pkg::MIN_SONGS);

  assign gen_in = (state == S_IDLE) ? {32'd0, entropy} : lfsr;
  assign gen_mix = (state == S_IDLE) ? entropy : ent_q;
  assign gen_out = spri_pkg::prng_step(gen_in, gen_mix);

  assign mod_start = (state == S_DRAW) ||
                     (accept && count_ok && (opcode == spri_pkg::OP_SEED));

  assign div_prod = {16'd0, song_length_seconds} * spri_pkg::DIV5_MUL;

  assign exp_diff = ram_rdata.expiry - now_q;
  assign hit = pend && (ram_rdata.id == trk_q) && !exp_diff[15];
  assign tries_full = (tries == TRY_LIMIT);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = write_slot;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = scan_cnt[AW-1:0];
    end else if (state == S_ADD) begin
      ram_we = 1'b1;
      ram_wdata.id = id_q;
      ram_wdata.expiry = now_q + quot_q;
    end
  end

  spri_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (gen_out[31:0] ^ gen_out[63:32]),
    .divisor   (song_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  spri_ram #(
    .WIDTH (spri_pkg::ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      song_count <= '0;
      lfsr <= '0;
      write_slot <= '0;
      scan_cnt <= '0;
      pend <= 1'b0;
      tries <= '0;
      done <= 1'b0;
      track <= '0;
      attempts <= '0;
      gave_up <= 1'b0;
      error <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        song_count <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt[AW-1:0] == SLOT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q <= spri_pkg::opcode_t'(opcode);
            ent_q <= entropy;
            id_q <= song_id;
            now_q <= current_time;
            prev_q <= prev_track;
            quot_q <= 16'(div_prod >> spri_pkg::DIV5_SHIFT);
            tries <= '0;
            if ((opcode inside {spri_pkg::OP_SEED, spri_pkg::OP_PICK}) && !count_ok) begin
              done <= 1'b1;
              track <= '0;
              attempts <= '0;
              gave_up <= 1'b0;
              error <= 1'b1;
            end else begin
              case (spri_pkg::opcode_t'(opcode))
                spri_pkg::OP_SEED: begin
                  lfsr <= gen_out;
                  tries <= AWN'(1);
                  state <= S_MOD;
                end
                spri_pkg::OP_ADD: begin
                  state <= S_ADD;
                end
                spri_pkg::OP_PICK: begin
                  state <= S_DRAW;
                end
                default: begin
                  done <= 1'b1;
                  track <= '0;
                  attempts <= '0;
                  gave_up <= 1'b0;
                  error <= 1'b0;
                end
              endcase
            end
          end
        end
        S_ADD: begin
          write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + AW'(1);
          done <= 1'b1;
          track <= '0;
          attempts <= '0;
          gave_up <= 1'b0;
          error <= 1'b0;
          state <= S_IDLE;
        end
        S_DRAW: begin
          lfsr <= gen_out;
          tries <= tries + AWN'(1);
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            trk_q <= mod_rem;
            if (op_q == spri_pkg::OP_SEED || mod_rem != prev_q) begin
              if (op_q == spri_pkg::OP_SEED) begin
                done <= 1'b1;
                track <= mod_rem;
                attempts <= tries[8:0];
                gave_up <= 1'b0;
                error <= 1'b0;
                state <= S_IDLE;
              end else begin
                scan_cnt <= '0;
                pend <= 1'b0;
                state <= S_SCAN;
              end
            end else if (tries_full) begin
              done <= 1'b1;
              track <= mod_rem;
              attempts <= tries[8:0];
              gave_up <= 1'b1;
              error <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_DRAW;
            end
          end
        end
        S_SCAN: begin
          if (hit || (scan_cnt == SCAN_END)) begin
            pend <= 1'b0;
            if (hit && !tries_full) begin
              state <= S_DRAW;
            end else begin
              done <= 1'b1;
              track <= trk_q;
              attempts <= tries[8:0];
              gave_up <= hit;
              error <= 1'b0;
              state <= S_IDLE;
            end
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
            pend <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPRI_ASSERT_SAME(a_error_clean, clk, rst, done && error,
                    track == 16'd0 && attempts == 9'd0 && !gave_up)
  `SPRI_ASSERT_SAME(a_gave_up_limit, clk, rst, done && gave_up, tries == TRY_LIMIT)
  `SPRI_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy || done)
  `SPRI_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)

endmodule
